### rtl/core/rmss_pkg.sv
// Shared types, codes and reset values of the motion safety supervisor.
`default_nettype none

package rmss_pkg;

	localparam int VEL_WIDTH_DEF = 16;
	localparam int LIMIT_W       = 15;
	localparam int TH2_W         = 2 * LIMIT_W;
	localparam int CMD_W         = 3;
	localparam int HEALTH_W      = 8;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = LIMIT_W;

	localparam logic [LIMIT_W-1:0] LIMIT_NORMAL_RST  = 15'd4096;
	localparam logic [LIMIT_W-1:0] LIMIT_DEGRADED_RST = 15'd1229;
	localparam logic [LIMIT_W-1:0] THRESHOLD_RST     = 15'd205;
	localparam logic [TH2_W-1:0]   THRESHOLD_SQ_RST  = 30'd42025;

	typedef enum logic [1:0] {
		MODE_NORMAL    = 2'd0,
		MODE_DEGRADED  = 2'd1,
		MODE_PSTOP     = 2'd2,
		MODE_EMERGENCY = 2'd3
	} mode_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_VELOCITY = 3'd0,
		CMD_HEALTH   = 3'd1,
		CMD_ODOMETRY = 3'd2,
		CMD_ESTOP    = 3'd3,
		CMD_RESET    = 3'd4
	} cmd_t;

	localparam logic [HEALTH_W-1:0] HC_STARTUP  = 8'd0;
	localparam logic [HEALTH_W-1:0] HC_EMERG    = 8'd1;
	localparam logic [HEALTH_W-1:0] HC_PSTOP    = 8'd2;
	localparam logic [HEALTH_W-1:0] HC_DEGRADED = 8'd3;
	localparam logic [HEALTH_W-1:0] HC_OK       = 8'd4;
	localparam logic [HEALTH_W-1:0] HC_RECONF   = 8'd5;

	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_NORMAL   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_DEGRADED = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE         = 2'd3;

	typedef struct packed {
		mode_t mode;
		logic  latched;
		logic  contactor;
	} sup_state_t;

	typedef struct packed {
		logic [LIMIT_W-1:0] limit_normal;
		logic [LIMIT_W-1:0] limit_degraded;
		logic [TH2_W-1:0]   threshold_sq;
		logic               enabled;
	} sup_cfg_t;

	typedef struct packed {
		logic       motor_valid;
		logic       contactors_closed;
		logic       report_valid;
		logic [1:0] reported_mode;
		logic       reset_ok;
	} res_flags_t;

endpackage

`default_nettype wire

### rtl/core/rmss_evt_if.sv
// Event channel: one supervisor event per beat.
`default_nettype none

interface rmss_evt_if #(parameter int VEL_WIDTH = 16) ();
	logic                        valid;
	logic                        ready;
	logic [2:0]                  command;
	logic signed [VEL_WIDTH-1:0] cmd_vx;
	logic signed [VEL_WIDTH-1:0] cmd_vy;
	logic signed [VEL_WIDTH-1:0] cmd_wz;
	logic [7:0]                  health_code;
	logic signed [VEL_WIDTH-1:0] odom_vx;
	logic signed [VEL_WIDTH-1:0] odom_vy;

	modport source (output valid, command, cmd_vx, cmd_vy, cmd_wz, health_code,
		odom_vx, odom_vy, input ready);
	modport sink (input valid, command, cmd_vx, cmd_vy, cmd_wz, health_code,
		odom_vx, odom_vy, output ready);
endinterface

`default_nettype wire

### rtl/core/rmss_res_if.sv
// Result channel: one supervisor result per beat.
`default_nettype none

interface rmss_res_if #(parameter int VEL_WIDTH = 16) ();
	logic                        valid;
	logic                        ready;
	logic                        motor_valid;
	logic signed [VEL_WIDTH-1:0] motor_vx;
	logic signed [VEL_WIDTH-1:0] motor_vy;
	logic signed [VEL_WIDTH-1:0] motor_wz;
	logic                        contactors_closed;
	logic                        report_valid;
	logic [1:0]                  reported_mode;
	logic                        reset_ok;

	modport source (output valid, motor_valid, motor_vx, motor_vy, motor_wz,
		contactors_closed, report_valid, reported_mode, reset_ok, input ready);
	modport sink (input valid, motor_valid, motor_vx, motor_vy, motor_wz,
		contactors_closed, report_valid, reported_mode, reset_ok, output ready);
endinterface

`default_nettype wire

### rtl/core/rmss_step.sv
// Event decode: next supervisor state and result fields for one event.
`default_nettype none

module rmss_step import rmss_pkg::*; #(
	parameter int VEL_WIDTH = VEL_WIDTH_DEF
) (
	input  logic [CMD_W-1:0]          command,
	input  logic [HEALTH_W-1:0]       health_code,
	input  logic signed [VEL_WIDTH-1:0] cmd_vx,
	input  logic signed [VEL_WIDTH-1:0] cmd_vy,
	input  logic signed [VEL_WIDTH-1:0] cmd_wz,
	input  logic [2*VEL_WIDTH-1:0]    sq_x,
	input  logic [2*VEL_WIDTH-1:0]    sq_y,
	input  sup_state_t                st,
	input  sup_cfg_t                  cfg,
	output sup_state_t                st_nxt,
	output res_flags_t                flags,
	output logic signed [VEL_WIDTH-1:0] motor_vx,
	output logic signed [VEL_WIDTH-1:0] motor_vy,
	output logic signed [VEL_WIDTH-1:0] motor_wz
);

	localparam int EXT_W = ((VEL_WIDTH > LIMIT_W) ? VEL_WIDTH : LIMIT_W) + 1;
	localparam int SQS_W = 2 * VEL_WIDTH + 1;
	localparam int CMP_W = (SQS_W > TH2_W) ? SQS_W : TH2_W;

	// Limit never exceeds the velocity range when it clips, so truncation is exact.
	function automatic logic signed [VEL_WIDTH-1:0] clamp(
		input logic signed [VEL_WIDTH-1:0] v,
		input logic [LIMIT_W-1:0] lim
	);
		logic signed [EXT_W-1:0] ve;
		logic signed [EXT_W-1:0] le;
		ve = EXT_W'(v);
		le = signed'(EXT_W'(lim));
		if (ve > le)
			return VEL_WIDTH'(le);
		else if (ve < -le)
			return VEL_WIDTH'(-le);
		else
			return v;
	endfunction

	logic [SQS_W-1:0]   speed_sq;
	logic               too_fast;
	logic [LIMIT_W-1:0] lim;
	logic               free_run;

	assign speed_sq = {1'b0, sq_x} + {1'b0, sq_y};
	assign too_fast = CMP_W'(speed_sq) > CMP_W'(cfg.threshold_sq);
	assign lim      = (st.mode == MODE_DEGRADED) ? cfg.limit_degraded : cfg.limit_normal;
	assign free_run = !st.latched && st.mode != MODE_PSTOP && st.mode != MODE_EMERGENCY;

	always_comb begin
		st_nxt            = st;
		flags             = '0;
		motor_vx          = '0;
		motor_vy          = '0;
		motor_wz          = '0;
		case (command)
			CMD_VELOCITY: begin
				if (cfg.enabled) begin
					flags.motor_valid = 1'b1;
					if (free_run) begin
						motor_vx = clamp(cmd_vx, lim);
						motor_vy = clamp(cmd_vy, lim);
						motor_wz = clamp(cmd_wz, lim);
					end
				end
			end
			CMD_HEALTH: begin
				if (cfg.enabled) begin
					case (health_code)
						HC_STARTUP: begin
							st_nxt.mode       = MODE_PSTOP;
							st_nxt.contactor  = 1'b0;
							flags.motor_valid = 1'b1;
						end
						HC_EMERG: begin
							st_nxt.mode       = MODE_EMERGENCY;
							st_nxt.latched    = 1'b1;
							st_nxt.contactor  = 1'b0;
							flags.motor_valid = 1'b1;
						end
						HC_PSTOP: begin
							st_nxt.mode       = MODE_PSTOP;
							flags.motor_valid = 1'b1;
							if (!st.latched)
								st_nxt.contactor = 1'b1;
						end
						HC_DEGRADED: begin
							st_nxt.mode = MODE_DEGRADED;
							if (!st.latched)
								st_nxt.contactor = 1'b1;
						end
						HC_OK: begin
							if (!st.latched) begin
								st_nxt.mode      = MODE_NORMAL;
								st_nxt.contactor = 1'b1;
							end
						end
						HC_RECONF: begin
							st_nxt.mode       = MODE_DEGRADED;
							flags.motor_valid = 1'b1;
							if (!st.latched)
								st_nxt.contactor = 1'b1;
						end
						default: begin
							st_nxt.contactor = 1'b0;
						end
					endcase
				end
			end
			CMD_ODOMETRY: begin
				if (cfg.enabled && st.mode == MODE_PSTOP && too_fast) begin
					st_nxt.mode        = MODE_EMERGENCY;
					st_nxt.latched     = 1'b1;
					st_nxt.contactor   = 1'b0;
					flags.report_valid = 1'b1;
				end
			end
			CMD_ESTOP: begin
				if (cfg.enabled) begin
					st_nxt.mode        = MODE_EMERGENCY;
					st_nxt.latched     = 1'b1;
					st_nxt.contactor   = 1'b0;
					flags.motor_valid  = 1'b1;
					flags.report_valid = 1'b1;
				end
			end
			CMD_RESET: begin
				// acted on even with processing disabled
				if (st.mode == MODE_EMERGENCY || st.latched) begin
					st_nxt.mode        = MODE_NORMAL;
					st_nxt.latched     = 1'b0;
					st_nxt.contactor   = 1'b1;
					flags.report_valid = 1'b1;
					flags.reset_ok     = 1'b1;
				end
			end
			default: begin
			end
		endcase
		flags.contactors_closed = st_nxt.contactor;
		if (flags.report_valid)
			flags.reported_mode = (st_nxt.latched || st_nxt.mode == MODE_EMERGENCY) ?
				MODE_EMERGENCY : st_nxt.mode;
	end

endmodule

`default_nettype wire

### rtl/core/robot_motion_safety_supervisor_top.sv
// Top level of the robot motion safety supervisor.
`default_nettype none

// Motion safety supervisor. Each event beat on evt (velocity command, health
// code, odometry, e-stop or latch reset) yields exactly one result beat on res.
// The block holds the supervision mode, the e-stop latch and the contactor drive;
// events act on them strictly in arrival order. Throughput is one event per
// clock while res.ready stays high. Each accepted event is held in the event
// register with its squared odometry axes; the decode logic then updates the
// state and loads the result register. The result register frees the input
// side, so one more event is taken while a finished result waits on res.ready;
// after that evt.ready drops until res drains. No clearing pass after reset.
// Configuration (limits in Q3.12, moving threshold, enable) is written through
// cfg_we/cfg_idx/cfg_data while the block is idle, a rule for the user that the
// block itself does not enforce; the squared threshold is registered from it.
module robot_motion_safety_supervisor_top import rmss_pkg::*; #(
	parameter int VEL_WIDTH = VEL_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	rmss_evt_if.sink              evt,
	rmss_res_if.source            res,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// configuration registers
	logic [LIMIT_W-1:0] limit_normal_q;
	logic [LIMIT_W-1:0] limit_degraded_q;
	logic [LIMIT_W-1:0] threshold_q;
	logic [TH2_W-1:0]   threshold_sq_q;
	logic               enabled_q;
	sup_cfg_t           cfg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_normal_q   <= LIMIT_NORMAL_RST;
			limit_degraded_q <= LIMIT_DEGRADED_RST;
			threshold_q      <= THRESHOLD_RST;
			threshold_sq_q   <= THRESHOLD_SQ_RST;
			enabled_q        <= 1'b0;
		end else begin
			threshold_sq_q <= TH2_W'(threshold_q) * TH2_W'(threshold_q);
			if (cfg_we) begin
				case (cfg_idx)
					REG_LIMIT_NORMAL:   limit_normal_q   <= cfg_data;
					REG_LIMIT_DEGRADED: limit_degraded_q <= cfg_data;
					REG_THRESHOLD:      threshold_q      <= cfg_data;
					REG_ENABLE:         enabled_q        <= cfg_data[0];
					default: begin
					end
				endcase
			end
		end
	end

	assign cfg.limit_normal   = limit_normal_q;
	assign cfg.limit_degraded = limit_degraded_q;
	assign cfg.threshold_sq   = threshold_sq_q;
	assign cfg.enabled        = enabled_q;

	// stage 1: event register, odometry squared on the way in
	logic                         s1_valid_s1;
	logic [CMD_W-1:0]             command_s1;
	logic [HEALTH_W-1:0]          health_code_s1;
	logic signed [VEL_WIDTH-1:0]  cmd_vx_s1;
	logic signed [VEL_WIDTH-1:0]  cmd_vy_s1;
	logic signed [VEL_WIDTH-1:0]  cmd_wz_s1;
	logic [2*VEL_WIDTH-1:0]       sq_x_s1;
	logic [2*VEL_WIDTH-1:0]       sq_y_s1;

	logic s1_adv;
	logic evt_take;

	// s1 moves on when the result register is empty or being drained
	assign s1_adv    = s1_valid_s1 && (!res.valid || res.ready);
	assign evt.ready = !s1_valid_s1 || s1_adv;
	assign evt_take  = evt.valid && evt.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_s1 <= 1'b0;
		else if (evt.ready)
			s1_valid_s1 <= evt.valid;
	end

	always_ff @(posedge clk) begin
		if (evt_take) begin
			command_s1     <= evt.command;
			health_code_s1 <= evt.health_code;
			cmd_vx_s1      <= evt.cmd_vx;
			cmd_vy_s1      <= evt.cmd_vy;
			cmd_wz_s1      <= evt.cmd_wz;
			sq_x_s1        <= (2*VEL_WIDTH)'(evt.odom_vx) * (2*VEL_WIDTH)'(evt.odom_vx);
			sq_y_s1        <= (2*VEL_WIDTH)'(evt.odom_vy) * (2*VEL_WIDTH)'(evt.odom_vy);
		end
	end

	// supervisor state, updated as each event leaves stage 1
	sup_state_t                  st_q;
	sup_state_t                  st_nxt;
	res_flags_t                  flags;
	logic signed [VEL_WIDTH-1:0] motor_vx;
	logic signed [VEL_WIDTH-1:0] motor_vy;
	logic signed [VEL_WIDTH-1:0] motor_wz;

	rmss_step #(.VEL_WIDTH(VEL_WIDTH)) u_step (
		.command     (command_s1),
		.health_code (health_code_s1),
		.cmd_vx      (cmd_vx_s1),
		.cmd_vy      (cmd_vy_s1),
		.cmd_wz      (cmd_wz_s1),
		.sq_x        (sq_x_s1),
		.sq_y        (sq_y_s1),
		.st          (st_q),
		.cfg         (cfg),
		.st_nxt      (st_nxt),
		.flags       (flags),
		.motor_vx    (motor_vx),
		.motor_vy    (motor_vy),
		.motor_wz    (motor_wz)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.mode      <= MODE_NORMAL;
			st_q.latched   <= 1'b0;
			st_q.contactor <= 1'b0;
		end else if (s1_adv) begin
			st_q <= st_nxt;
		end
	end

	// result register
	logic                        res_valid_q;
	res_flags_t                  flags_q;
	logic signed [VEL_WIDTH-1:0] motor_vx_q;
	logic signed [VEL_WIDTH-1:0] motor_vy_q;
	logic signed [VEL_WIDTH-1:0] motor_wz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (s1_adv)
			res_valid_q <= 1'b1;
		else if (res.ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			flags_q    <= flags;
			motor_vx_q <= motor_vx;
			motor_vy_q <= motor_vy;
			motor_wz_q <= motor_wz;
		end
	end

	assign res.valid             = res_valid_q;
	assign res.motor_valid       = flags_q.motor_valid;
	assign res.motor_vx          = motor_vx_q;
	assign res.motor_vy          = motor_vy_q;
	assign res.motor_wz          = motor_wz_q;
	assign res.contactors_closed = flags_q.contactors_closed;
	assign res.report_valid      = flags_q.report_valid;
	assign res.reported_mode     = flags_q.reported_mode;
	assign res.reset_ok          = flags_q.reset_ok;

	// contactors only close once the latch is clear
	a_close_unlatched: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(st_q.contactor) |-> !st_q.latched)
		else $error("contactor closed while e-stop latched");

	// a report is either an escalation or an accepted latch reset
	a_report_kind: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && flags_q.report_valid |->
			flags_q.reported_mode == MODE_EMERGENCY ||
			(flags_q.reset_ok && flags_q.reported_mode == MODE_NORMAL))
		else $error("unexpected report mode");

	a_reset_reports: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && flags_q.reset_ok |-> flags_q.report_valid && flags_q.contactors_closed)
		else $error("accepted reset without report or closed contactors");

	a_idle_motor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !flags_q.motor_valid |->
			motor_vx_q == '0 && motor_vy_q == '0 && motor_wz_q == '0)
		else $error("motor command without motor_valid");

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for the robot motion safety supervisor top level.
`timescale 1ns / 100ps

module tb_top;
	import rmss_pkg::*;

	localparam int VW          = VEL_WIDTH_DEF;
	localparam int VEL_MAX     = (1 << (VW - 1)) - 1;
	localparam int LIMIT_MAX   = (1 << LIMIT_W) - 1;
	localparam int LONG_STALL  = 200;
	localparam int SETTLE      = 4;    // covers the result register plus the threshold square refresh
	localparam int TIMEOUT_NS  = 5_000_000;

	// Command codes the block must ignore.
	localparam logic [CMD_W-1:0]    CMD_UNUSED_FIRST = 3'd5;
	localparam logic [CMD_W-1:0]    CMD_UNUSED_LAST  = 3'd7;
	// Health codes with no defined meaning.
	localparam logic [HEALTH_W-1:0] HC_UNKNOWN_FIRST = 8'd6;
	localparam logic [HEALTH_W-1:0] HC_UNKNOWN_LAST  = 8'd255;

	typedef struct {
		logic [CMD_W-1:0]        command;
		logic signed [VW-1:0]    cmd_vx;
		logic signed [VW-1:0]    cmd_vy;
		logic signed [VW-1:0]    cmd_wz;
		logic [HEALTH_W-1:0]     health_code;
		logic signed [VW-1:0]    odom_vx;
		logic signed [VW-1:0]    odom_vy;
	} sup_event_t;

	typedef struct {
		logic                    motor_valid;
		logic signed [VW-1:0]    motor_vx;
		logic signed [VW-1:0]    motor_vy;
		logic signed [VW-1:0]    motor_wz;
		logic                    contactors_closed;
		logic                    report_valid;
		logic [1:0]              reported_mode;
		logic                    reset_ok;
	} sup_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	rmss_evt_if #(.VEL_WIDTH(VW)) evt_ch ();
	rmss_res_if #(.VEL_WIDTH(VW)) res_ch ();

	robot_motion_safety_supervisor_top #(.VEL_WIDTH(VW)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.evt      (evt_ch),
		.res      (res_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	// Event beats waiting to be offered, and results owed by the block in order.
	sup_event_t  events_to_send[$];
	sup_result_t expected_results[$];
	sup_event_t  on_wire;          // event currently offered on evt

	int mismatch_count = 0;
	int send_idle_pct  = 0;        // chance per cycle that the sender stays idle
	int recv_stall_pct = 0;        // chance per cycle that the receiver holds ready low
	int stall_left;                // cycles left of a long receiver hold-off
	bit stall_kick;

	// Mirror of the supervisor: state and configuration as the block should hold them.
	mode_t st_mode;
	bit    st_latched;
	bit    st_contactor;
	int    lim_normal;
	int    lim_degraded;
	int    threshold;
	bit    enabled;

	//------------------------------------------------------------------
	// Clock and time limit
	//------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Test completed with failures");
		$finish;
	end

	//------------------------------------------------------------------
	// Predictor
	//------------------------------------------------------------------
	function automatic logic signed [VW-1:0] clamp_speed(int v, int lim);
		if (v > lim)
			return VW'(lim);
		if (v < -lim)
			return VW'(-lim);
		return VW'(v);
	endfunction

	// Applies one event to the mirrored state and returns the result beat it yields.
	function automatic sup_result_t supervise_event(sup_event_t e);
		sup_result_t r;
		int          lim;
		longint      ax;
		longint      ay;
		r = '{default: '0};
		if (e.command == CMD_VELOCITY && enabled) begin
			// zero command while stopped or latched, clamped otherwise
			r.motor_valid = 1'b1;
			if (!st_latched && st_mode != MODE_PSTOP && st_mode != MODE_EMERGENCY) begin
				lim = (st_mode == MODE_DEGRADED) ? lim_degraded : lim_normal;
				r.motor_vx = clamp_speed(e.cmd_vx, lim);
				r.motor_vy = clamp_speed(e.cmd_vy, lim);
				r.motor_wz = clamp_speed(e.cmd_wz, lim);
			end
		end else if (e.command == CMD_HEALTH && enabled) begin
			case (e.health_code)
				HC_STARTUP: begin
					st_mode = MODE_PSTOP;
					r.motor_valid = 1'b1;
					st_contactor = 1'b0;
				end
				HC_EMERG: begin
					st_latched = 1'b1;
					st_mode = MODE_EMERGENCY;
					r.motor_valid = 1'b1;
					st_contactor = 1'b0;
				end
				HC_PSTOP: begin
					st_mode = MODE_PSTOP;
					r.motor_valid = 1'b1;
					if (!st_latched)
						st_contactor = 1'b1;
				end
				HC_DEGRADED: begin
					st_mode = MODE_DEGRADED;
					if (!st_latched)
						st_contactor = 1'b1;
				end
				HC_OK: begin
					if (!st_latched) begin
						st_mode = MODE_NORMAL;
						st_contactor = 1'b1;
					end
				end
				HC_RECONF: begin
					st_mode = MODE_DEGRADED;
					r.motor_valid = 1'b1;
					if (!st_latched)
						st_contactor = 1'b1;
				end
				default: st_contactor = 1'b0;
			endcase
		end else if (e.command == CMD_ODOMETRY && enabled) begin
			ax = e.odom_vx;
			ay = e.odom_vy;
			if (st_mode == MODE_PSTOP &&
				ax * ax + ay * ay > longint'(threshold) * longint'(threshold)) begin
				st_latched = 1'b1;
				st_mode = MODE_EMERGENCY;
				st_contactor = 1'b0;
				r.report_valid = 1'b1;
			end
		end else if (e.command == CMD_ESTOP && enabled) begin
			st_latched = 1'b1;
			st_mode = MODE_EMERGENCY;
			r.motor_valid = 1'b1;
			st_contactor = 1'b0;
			r.report_valid = 1'b1;
		end else if (e.command == CMD_RESET) begin
			// acted on even while processing is disabled
			if (st_mode == MODE_EMERGENCY || st_latched) begin
				st_mode = MODE_NORMAL;
				st_latched = 1'b0;
				st_contactor = 1'b1;
				r.report_valid = 1'b1;
				r.reset_ok = 1'b1;
			end
		end
		r.contactors_closed = st_contactor;
		if (r.report_valid)
			r.reported_mode = (st_latched || st_mode == MODE_EMERGENCY) ? MODE_EMERGENCY : st_mode;
		return r;
	endfunction

	//------------------------------------------------------------------
	// Event driver: offers queued beats, predicts each one as it is taken
	//------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_ch.valid       <= 1'b0;
			evt_ch.command     <= '0;
			evt_ch.cmd_vx      <= '0;
			evt_ch.cmd_vy      <= '0;
			evt_ch.cmd_wz      <= '0;
			evt_ch.health_code <= '0;
			evt_ch.odom_vx     <= '0;
			evt_ch.odom_vy     <= '0;
		end else begin
			if (evt_ch.valid && evt_ch.ready)
				expected_results.push_back(supervise_event(on_wire));
			// valid only changes once the current beat has gone
			if (!evt_ch.valid || evt_ch.ready) begin
				if (events_to_send.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					on_wire = events_to_send.pop_front();
					evt_ch.valid       <= 1'b1;
					evt_ch.command     <= on_wire.command;
					evt_ch.cmd_vx      <= on_wire.cmd_vx;
					evt_ch.cmd_vy      <= on_wire.cmd_vy;
					evt_ch.cmd_wz      <= on_wire.cmd_wz;
					evt_ch.health_code <= on_wire.health_code;
					evt_ch.odom_vx     <= on_wire.odom_vx;
					evt_ch.odom_vy     <= on_wire.odom_vy;
				end else begin
					evt_ch.valid <= 1'b0;
				end
			end
		end
	end

	//------------------------------------------------------------------
	// Result monitor: random back-pressure and in-order compare
	//------------------------------------------------------------------
	// Long hold-off counter, kicked from the stimulus process.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_left <= 0;
		end else if (stall_kick) begin
			stall_left <= LONG_STALL;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end
	end

	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		sup_result_t want;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= (stall_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
			if (res_ch.valid && res_ch.ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t ns: result beat with nothing expected, actual motor_valid %0b",
						$time, res_ch.motor_valid);
					mismatch_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("motor_valid", want.motor_valid, res_ch.motor_valid);
					check_field("motor_vx", want.motor_vx, res_ch.motor_vx);
					check_field("motor_vy", want.motor_vy, res_ch.motor_vy);
					check_field("motor_wz", want.motor_wz, res_ch.motor_wz);
					check_field("contactors_closed", want.contactors_closed,
						res_ch.contactors_closed);
					check_field("report_valid", want.report_valid, res_ch.report_valid);
					check_field("reported_mode", want.reported_mode, res_ch.reported_mode);
					check_field("reset_ok", want.reset_ok, res_ch.reset_ok);
				end
			end
		end
	end

	//------------------------------------------------------------------
	// Stimulus helpers
	//------------------------------------------------------------------
	// Event of the given kind with every payload field random.
	function automatic sup_event_t noise_event(logic [CMD_W-1:0] cmd);
		sup_event_t e;
		e.command     = cmd;
		e.cmd_vx      = VW'($urandom);
		e.cmd_vy      = VW'($urandom);
		e.cmd_wz      = VW'($urandom);
		e.health_code = HEALTH_W'($urandom);
		e.odom_vx     = VW'($urandom);
		e.odom_vy     = VW'($urandom);
		return e;
	endfunction

	// Speed of random sign around a bound, to land on both sides of a clamp or threshold.
	function automatic logic signed [VW-1:0] speed_near(int bound);
		int mag;
		mag = $urandom_range(0, bound + bound / 8 + 2);
		if (mag > VEL_MAX)
			mag = VEL_MAX;
		return $urandom_range(0, 1) ? VW'(-mag) : VW'(mag);
	endfunction

	task automatic send_vel(int vx, int vy, int wz);
		sup_event_t e;
		e = noise_event(CMD_VELOCITY);
		e.cmd_vx = VW'(vx);
		e.cmd_vy = VW'(vy);
		e.cmd_wz = VW'(wz);
		events_to_send.push_back(e);
	endtask

	task automatic send_health(logic [HEALTH_W-1:0] hc);
		sup_event_t e;
		e = noise_event(CMD_HEALTH);
		e.health_code = hc;
		events_to_send.push_back(e);
	endtask

	task automatic send_odom(int vx, int vy);
		sup_event_t e;
		e = noise_event(CMD_ODOMETRY);
		e.odom_vx = VW'(vx);
		e.odom_vy = VW'(vy);
		events_to_send.push_back(e);
	endtask

	task automatic send_plain(logic [CMD_W-1:0] cmd);
		events_to_send.push_back(noise_event(cmd));
	endtask

	// Mostly well-formed traffic with a bias toward clamp and threshold edges.
	function automatic sup_event_t random_event();
		sup_event_t e;
		int         pick;
		int         lim;
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			e = noise_event(CMD_VELOCITY);
			if ($urandom_range(0, 1)) begin
				lim = $urandom_range(0, 1) ? lim_normal : lim_degraded;
				e.cmd_vx = speed_near(lim);
				e.cmd_vy = speed_near(lim);
				e.cmd_wz = speed_near(lim);
			end
		end else if (pick < 55) begin
			e = noise_event(CMD_HEALTH);
			if ($urandom_range(0, 99) < 85)
				e.health_code = HEALTH_W'($urandom_range(HC_STARTUP, HC_RECONF));
			else
				e.health_code = HEALTH_W'($urandom_range(HC_UNKNOWN_FIRST, HC_UNKNOWN_LAST));
		end else if (pick < 75) begin
			e = noise_event(CMD_ODOMETRY);
			if ($urandom_range(0, 1)) begin
				e.odom_vx = speed_near(threshold);
				e.odom_vy = speed_near(threshold / 2);
			end
		end else if (pick < 80) begin
			e = noise_event(CMD_ESTOP);
		end else if (pick < 95) begin
			e = noise_event(CMD_RESET);
		end else begin
			e = noise_event(CMD_W'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST)));
		end
		return e;
	endfunction

	// Wait until every queued beat is taken and every result has come back.
	task automatic drain();
		while (events_to_send.size() != 0 || evt_ch.valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= CFG_DATA_W'(value);
		case (idx)
			REG_LIMIT_NORMAL:   lim_normal = value;
			REG_LIMIT_DEGRADED: lim_degraded = value;
			REG_THRESHOLD:      threshold = value;
			REG_ENABLE:         enabled = (value != 0);
			default: begin
			end
		endcase
	endtask

	// Back-to-back writes of all four registers, then time for the squared threshold.
	task automatic apply_config(int ln, int ld, int th, int en);
		write_reg(REG_LIMIT_NORMAL, ln);
		write_reg(REG_LIMIT_DEGRADED, ld);
		write_reg(REG_THRESHOLD, th);
		write_reg(REG_ENABLE, en);
		@(posedge clk);
		cfg_we <= 1'b0;
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic run_random(int count, int idle_pct, int stall_pct, bit pause_midway);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		for (int i = 0; i < count; i++) begin
			events_to_send.push_back(random_event());
			// sender pause: let the block run dry before the second half
			if (pause_midway && i == count / 2)
				drain();
		end
		drain();
	endtask

	//------------------------------------------------------------------
	// Test sequence
	//------------------------------------------------------------------
	initial begin
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_idx            = '0;
		cfg_data           = '0;
		evt_ch.valid       = 1'b0;
		evt_ch.command     = '0;
		evt_ch.cmd_vx      = '0;
		evt_ch.cmd_vy      = '0;
		evt_ch.cmd_wz      = '0;
		evt_ch.health_code = '0;
		evt_ch.odom_vx     = '0;
		evt_ch.odom_vy     = '0;
		res_ch.ready       = 1'b0;

		st_mode      = MODE_NORMAL;
		st_latched   = 1'b0;
		st_contactor = 1'b0;
		lim_normal   = LIMIT_NORMAL_RST;
		lim_degraded = LIMIT_DEGRADED_RST;
		threshold    = THRESHOLD_RST;
		enabled      = 1'b0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Out of reset processing is off: everything but reset is a no-op,
		// and reset itself is ignored since nothing is latched.
		send_vel(VEL_MAX, -VEL_MAX - 1, 1);
		send_health(HC_EMERG);
		send_odom(-VEL_MAX - 1, VEL_MAX);
		send_plain(CMD_ESTOP);
		send_plain(CMD_RESET);
		send_plain(CMD_UNUSED_FIRST);
		drain();

		apply_config(LIMIT_NORMAL_RST, LIMIT_DEGRADED_RST, THRESHOLD_RST, 1);

		// Walk the mode machine through every health code and command.
		send_vel(VEL_MAX, -VEL_MAX - 1, 100);       // clamp both ways in normal
		send_health(HC_OK);                          // contactors close
		send_health(HC_DEGRADED);
		send_vel(2000, -2000, -VEL_MAX - 1);         // degraded clamp
		send_health(HC_RECONF);                      // zero command, stays degraded
		send_health(HC_STARTUP);                     // protective stop, contactors open
		send_vel(VEL_MAX, VEL_MAX, VEL_MAX);         // zeroed while stopped
		send_odom(100, 100);                         // below threshold
		send_health(HC_PSTOP);                       // contactors close, still stopped
		send_odom(THRESHOLD_RST, 0);                 // exactly at threshold: no escalation
		send_odom(-VEL_MAX - 1, -VEL_MAX - 1);       // escalates, report
		send_plain(CMD_RESET);                       // accepted
		send_plain(CMD_RESET);                       // nothing to clear
		send_health(HC_UNKNOWN_LAST);                // unknown: contactors open
		send_plain(CMD_ESTOP);                       // latch
		send_health(HC_OK);                          // ignored while latched
		send_health(HC_PSTOP);                       // mode moves, contactors kept
		send_health(HC_DEGRADED);
		send_vel(500, -500, 500);                    // zeroed while latched
		send_plain(CMD_UNUSED_LAST);
		send_health(HC_EMERG);
		send_plain(CMD_RESET);
		send_health(HC_UNKNOWN_FIRST);
		send_plain(CMD_ESTOP);
		drain();

		// Latched, then disabled: reset must still clear the latch.
		apply_config(LIMIT_NORMAL_RST, LIMIT_DEGRADED_RST, THRESHOLD_RST, 0);
		send_plain(CMD_RESET);
		send_vel(1, 1, 1);
		send_health(HC_EMERG);
		send_plain(CMD_RESET);
		drain();

		// Random traffic under each idling pattern and a spread of settings.
		apply_config($urandom_range(0, LIMIT_MAX), $urandom_range(0, LIMIT_MAX),
			$urandom_range(0, 8000), 1);
		run_random(150, 0, 0, 1'b0);

		apply_config(LIMIT_MAX, LIMIT_MAX, LIMIT_MAX, 1);
		run_random(150, 67, 0, 1'b0);

		apply_config(0, 0, 0, 1);
		run_random(150, 0, 67, 1'b0);

		apply_config($urandom_range(0, LIMIT_MAX), $urandom_range(0, 4096),
			$urandom_range(0, 2000), 1);
		run_random(150, 16, 16, 1'b1);

		// Long receiver hold-off while the sender keeps pushing at full rate,
		// so the result side backs up and evt.ready has to drop.
		apply_config(LIMIT_NORMAL_RST, LIMIT_DEGRADED_RST, THRESHOLD_RST, 1);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		for (int i = 0; i < 100; i++)
			events_to_send.push_back(random_event());
		@(posedge clk);
		stall_kick <= 1'b1;
		@(posedge clk);
		stall_kick <= 1'b0;
		drain();

		// Disabled again with random traffic: only resets may act.
		apply_config($urandom_range(0, LIMIT_MAX), $urandom_range(0, LIMIT_MAX),
			$urandom_range(0, LIMIT_MAX), 0);
		run_random(50, 16, 16, 1'b0);

		if (mismatch_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/core/rmss_pkg.sv
rtl/core/rmss_evt_if.sv
rtl/core/rmss_res_if.sv
rtl/core/rmss_step.sv
rtl/core/robot_motion_safety_supervisor_top.sv
tb/tb_top.sv
